FILE: sv/ckrb_pkg.sv
`default_nettype none

package ckrb_pkg;

  // Field widths fixed by the item format
  localparam int unsigned CharW     = 9;
  localparam int unsigned CmdW      = 2;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned HistLimW  = 9;
  localparam int unsigned CkptLimW  = 5;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 9;

  typedef logic [CmdW-1:0]       cmd_t;
  typedef logic signed [CharW-1:0] char_t;
  typedef logic [StatusW-1:0]    status_t;
  typedef logic [CfgIdxW-1:0]    cfg_idx_t;
  typedef logic [CfgDataW-1:0]   cfg_data_t;

  // Command codes
  localparam cmd_t CMD_GET      = 2'd0;
  localparam cmd_t CMD_PUSH     = 2'd1;
  localparam cmd_t CMD_COMMIT   = 2'd2;
  localparam cmd_t CMD_ROLLBACK = 2'd3;

  // Status codes
  localparam status_t ST_OK          = 2'd0;
  localparam status_t ST_HIST_FULL   = 2'd1;
  localparam status_t ST_STACK_FULL  = 2'd2;
  localparam status_t ST_STACK_EMPTY = 2'd3;

  // Configuration register indexes
  localparam cfg_idx_t REG_HISTORY_LIMIT    = 1'd0;
  localparam cfg_idx_t REG_CHECKPOINT_LIMIT = 1'd1;

  // Register reset values
  localparam logic [HistLimW-1:0] HistLimReset = 9'd256;
  localparam logic [CkptLimW-1:0] CkptLimReset = 5'd16;

endpackage

`default_nettype wire

FILE: sv/ckrb_if.sv
`default_nettype none

// Command beat channel
interface ckrb_in_if;
  logic              valid;
  logic              ready;
  ckrb_pkg::cmd_t    command;
  ckrb_pkg::char_t   fresh_char;

  modport source (output valid, output command, output fresh_char, input ready);
  modport sink   (input valid, input command, input fresh_char, output ready);
endinterface

// Result beat channel
interface ckrb_out_if;
  logic               valid;
  logic               ready;
  ckrb_pkg::char_t    char_out;
  logic               source_consumed;
  ckrb_pkg::status_t  status;

  modport source (output valid, output char_out, output source_consumed, output status,
                  input ready);
  modport sink   (input valid, input char_out, input source_consumed, input status,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/ckrb_ram.sv
`default_nettype none

module ckrb_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/checkpoint_replay_char_buffer.sv
`default_nettype none

// Backtracking character buffer for a parser. Each command beat gives one result beat.
// A get replays the recorded history first, then takes fresh_char from the source and
// records it while a checkpoint is open; push, commit and rollback work a stack of
// saved replay positions. The history and checkpoint RAMs are read when the beat is
// accepted, and the result is formed and written back in the execute state, so a new
// command is accepted only after the last one has executed, while the result register
// drains. A result still waiting on the sink holds the write-back cycle, and with it the
// acceptance of the following beat, until that result is taken.
// Write the configuration only while no command is in flight; the limits are read when
// a command executes. No clearing pass: only entries below the fill or stack depth are
// ever read.
module checkpoint_replay_char_buffer #(
  parameter int unsigned HISTORY_DEPTH    = 256,
  parameter int unsigned CHECKPOINT_DEPTH = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire ckrb_pkg::cfg_idx_t   cfg_index_i,
  input  wire ckrb_pkg::cfg_data_t  cfg_data_i,
  ckrb_in_if.sink                   in_ch,
  ckrb_out_if.source                out_ch
);

  import ckrb_pkg::*;

  // Pointer widths follow the depths
  localparam int unsigned FW  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned HAW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(CHECKPOINT_DEPTH + 1);
  localparam int unsigned SAW = (CHECKPOINT_DEPTH > 1) ? $clog2(CHECKPOINT_DEPTH) : 1;
  localparam int unsigned LW  = ((FW > HistLimW) ? FW : HistLimW) + 1;
  localparam int unsigned CLW = ((CW > CkptLimW) ? CW : CkptLimW) + 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                state_q, state_d;
  logic [HistLimW-1:0] hist_limit_q;
  logic [CkptLimW-1:0] ckpt_limit_q;
  logic [FW-1:0]       fill_q, fill_d;
  logic [FW-1:0]       pos_q, pos_d;
  logic [CW-1:0]       depth_q, depth_d;
  cmd_t                cmd_q;
  char_t               fresh_q;

  logic                out_valid_q, out_valid_d;
  char_t               char_q, char_d;
  logic                consumed_q, consumed_d;
  status_t             status_q, status_d;

  logic                accept;
  logic                fire;
  logic                hist_we, stack_we;
  logic [CharW-1:0]    hist_rdata;
  logic [FW-1:0]       stack_rdata;
  logic [FW-1:0]       pos_inc;
  logic [CW-1:0]       depth_dec;
  logic                replay_hit;
  logic                hist_room;
  logic                stack_room;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_q == S_IDLE);
  assign fire     = (state_q == S_EXEC) && (!out_valid_q || out_ch.ready);

  assign pos_inc    = pos_q + 1'b1;
  assign depth_dec  = depth_q - 1'b1;
  assign replay_hit = (pos_q < fill_q);
  assign hist_room  = (LW'(fill_q) < LW'(hist_limit_q)) && (LW'(fill_q) < LW'(HISTORY_DEPTH));
  assign stack_room = (CLW'(depth_q) < CLW'(ckpt_limit_q)) &&
                      (CLW'(depth_q) < CLW'(CHECKPOINT_DEPTH));

  // History store
  ckrb_ram #(
    .WIDTH (CharW),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (fill_q[HAW-1:0]),
    .wdata_i (fresh_q),
    .re_i    (accept),
    .raddr_i (pos_q[HAW-1:0]),
    .rdata_o (hist_rdata)
  );

  // Checkpoint stack
  ckrb_ram #(
    .WIDTH (FW),
    .DEPTH (CHECKPOINT_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stack_we),
    .waddr_i (depth_q[SAW-1:0]),
    .wdata_i (pos_q),
    .re_i    (accept),
    .raddr_i (depth_dec[SAW-1:0]),
    .rdata_o (stack_rdata)
  );

  // Execute the held command against the read data
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    pos_d       = pos_q;
    depth_d     = depth_q;
    hist_we     = 1'b0;
    stack_we    = 1'b0;
    out_valid_d = out_valid_q && !out_ch.ready;
    char_d      = char_q;
    consumed_d  = consumed_q;
    status_d    = status_q;

    if (accept) begin
      state_d = S_EXEC;
    end

    if (fire) begin
      state_d     = S_IDLE;
      out_valid_d = 1'b1;
      char_d      = '0;
      consumed_d  = 1'b0;
      status_d    = ST_OK;
      case (cmd_q)
        CMD_GET: begin
          if (replay_hit) begin
            // Replay from history; release it once caught up with no checkpoint open
            char_d = char_t'(hist_rdata);
            pos_d  = pos_inc;
            if (pos_inc == fill_q && depth_q == '0) begin
              fill_d = '0;
              pos_d  = '0;
            end
          end else begin
            char_d     = fresh_q;
            consumed_d = 1'b1;
            if (depth_q != '0) begin
              if (hist_room) begin
                hist_we = 1'b1;
                fill_d  = fill_q + 1'b1;
                pos_d   = fill_q + 1'b1;
              end else begin
                status_d = ST_HIST_FULL;
              end
            end
          end
        end
        CMD_PUSH: begin
          if (stack_room) begin
            stack_we = 1'b1;
            depth_d  = depth_q + 1'b1;
          end else begin
            status_d = ST_STACK_FULL;
          end
        end
        default: begin
          // Commit and rollback pop the top entry
          if (depth_q == '0) begin
            status_d = ST_STACK_EMPTY;
          end else begin
            depth_d = depth_dec;
            if (cmd_q == CMD_ROLLBACK) begin
              pos_d = stack_rdata;
            end
          end
        end
      endcase
    end
  end

  // Control and pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      pos_q       <= '0;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      pos_q       <= pos_d;
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_limit_q <= HistLimReset;
      ckpt_limit_q <= CkptLimReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_HISTORY_LIMIT:    hist_limit_q <= cfg_data_i[HistLimW-1:0];
        REG_CHECKPOINT_LIMIT: ckpt_limit_q <= cfg_data_i[CkptLimW-1:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted beat and the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= in_ch.command;
      fresh_q <= in_ch.fresh_char;
    end
    char_q     <= char_d;
    consumed_q <= consumed_d;
    status_q   <= status_d;
  end

  assign out_ch.valid           = out_valid_q;
  assign out_ch.char_out        = char_q;
  assign out_ch.source_consumed = consumed_q;
  assign out_ch.status          = status_q;

endmodule

`default_nettype wire
